@@ rtl/core/tdpc_pkg.sv @@
package tdpc_pkg;

    localparam int CAND_W  = 32;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TEST = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

@@ rtl/core/trial_division_prime_counter_top.sv @@
// Flow: 0, 1, 2 and even values go from ST_IDLE straight to ST_DONE; odd values
// loop through ST_TEST and ST_WAIT once per odd trial divisor, up to ~sqrt(v)/2.
// A 32-bit prime tries ~32768 odd divisors before ST_DONE loads the result.
// Throughput: one item at a time, set by the shared bit-serial divider.
// Output register lets the next item start while a result waits.
// rst_n (async, active low) clears the prime count and all control state.
module trial_division_prime_counter_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tdpc_pkg::CAND_W-1:0]  s_tdata,   // [31:0] candidate
    input  logic                         s_tuser,   // [0] restart
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tdpc_pkg::COUNT_W-1:0] m_tdata,   // [31:0] prime_total
    output logic                         m_tuser    // [0] is_prime
);

    localparam int VW = (VALUE_WIDTH < tdpc_pkg::CAND_W) ? VALUE_WIDTH : tdpc_pkg::CAND_W;

    tdpc_pkg::state_t state_reg, state_next;

    logic [VW-1:0]                val_reg, val_next;
    logic [VW-1:0]                d_reg, d_next;
    logic                         prime_reg, prime_next;
    logic [tdpc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         ovalid_reg, ovalid_next;
    logic                         oprime_reg, oprime_next;
    logic [tdpc_pkg::COUNT_W-1:0] ototal_reg, ototal_next;

    logic          in_xfer;
    logic          load_out;
    logic          div_start;
    logic          div_done;
    logic [VW-1:0] div_q;
    logic [VW-1:0] div_r;
    logic [VW-1:0] v_in;

    assign v_in     = s_tdata[VW-1:0];
    assign s_tready = (state_reg == tdpc_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign load_out = (state_reg == tdpc_pkg::ST_DONE) && (!ovalid_reg || m_tready);
    assign div_start = (state_reg == tdpc_pkg::ST_TEST);

    tdpc_div #(
        .VW(VW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (val_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        d_next      = d_reg;
        prime_next  = prime_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        oprime_next = oprime_reg;
        ototal_next = ototal_reg;

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            tdpc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    val_next = v_in;
                    d_next   = VW'(3);
                    if (s_tuser)
                        count_next = '0;
                    if (v_in <= VW'(1))
                    begin
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else if (v_in == VW'(2))
                    begin
                        prime_next = 1'b1;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else if (!v_in[0])
                    begin
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tdpc_pkg::ST_TEST;
                    end
                end
            end
            tdpc_pkg::ST_TEST:
            begin
                state_next = tdpc_pkg::ST_WAIT;
            end
            tdpc_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    if (d_reg > div_q)
                    begin
                        prime_next = 1'b1;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else if (div_r == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = tdpc_pkg::ST_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + VW'(2);
                        state_next = tdpc_pkg::ST_TEST;
                    end
                end
            end
            tdpc_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    if (prime_reg && (count_reg != tdpc_pkg::COUNT_MAX))
                    begin
                        count_next  = count_reg + tdpc_pkg::COUNT_W'(1);
                        ototal_next = count_reg + tdpc_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        ototal_next = count_reg;
                    end
                    oprime_next = prime_reg;
                    ovalid_next = 1'b1;
                    state_next  = tdpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tdpc_pkg::ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        d_reg      <= d_next;
        prime_reg  <= prime_next;
        oprime_reg <= oprime_next;
        ototal_reg <= ototal_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ototal_reg;
    assign m_tuser  = oprime_reg;

endmodule

@@ rtl/core/tdpc_div.sv @@
module tdpc_div #(
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(VW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, dvd_reg[VW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VW - 1);
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[VW-2:0], 1'b0};
            quo_next = {quo_reg[VW-2:0], fits};
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/tdpc_checker.sv @@
module tdpc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tdpc_pkg::COUNT_W-1:0] m_tdata,
    input logic                         m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // a prime result never reports a zero total
    a_prime_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata != '0)
        else $error("prime result with zero total");

    // new result only comes from a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind trial_division_prime_counter_top tdpc_checker u_tdpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
